>>> rtl/bounding_box_and_sphere_builder_assert.svh
// Assertion macros for the bounding box and sphere builder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BOUNDING_BOX_AND_SPHERE_BUILDER_ASSERT_SVH
`define BOUNDING_BOX_AND_SPHERE_BUILDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BBSB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BBSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bbsb_pkg.sv
// Shared types, constants and fp32 helper functions for the box builder.
// No dependencies; every block file but the queue and the header imports it.
`timescale 1ns / 1ps

package bbsb_pkg;

	localparam int MQ_DEPTH_DEF = 4;
	localparam int OQ_DEPTH_DEF = 8;

	localparam logic [31:0] ROOT_BIAS   = 32'h1fc00000;
	localparam logic [31:0] SIGN_BIT    = 32'h80000000;
	localparam logic [31:0] QUIET_BIT   = 32'h00400000;
	localparam logic [31:0] DEFAULT_NAN = 32'hffc00000;
	localparam logic [31:0] FP_HALF     = 32'h3f000000;

	typedef enum logic [1:0] {
		REG_SYMMETRIC   = 2'd0,
		REG_CUBE        = 2'd1,
		REG_SEPARATE_XZ = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [31:0] point_z;
		logic [31:0] offset_x;
		logic [31:0] offset_y;
		logic [31:0] offset_z;
		logic        use_offset;
		logic        is_last;
	} point_t;

	typedef struct packed {
		logic [31:0] min_x;
		logic [31:0] min_y;
		logic [31:0] min_z;
		logic [31:0] max_x;
		logic [31:0] max_y;
		logic [31:0] max_z;
		logic [31:0] center_x;
		logic [31:0] center_y;
		logic [31:0] center_z;
		logic [31:0] radius;
	} result_t;

	// Raw running box handed from the front to the back, index 0 is x.
	typedef struct packed {
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
	} box_t;

	typedef struct packed {
		logic symmetric;
		logic cube;
		logic separate_xz;
	} mode_t;

	function automatic logic fp_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic fp_is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
	endfunction

	// Ordered less-than: false when either side is NaN, and -0 equals +0.
	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (fp_is_nan(a) || fp_is_nan(b)) begin
			r = 1'b0;
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			r = 1'b0;
		end else if (a[31] != b[31]) begin
			r = a[31];
		end else if (!a[31]) begin
			r = a[30:0] < b[30:0];
		end else begin
			r = a[30:0] > b[30:0];
		end
		return r;
	endfunction

	// Packs a rounded significand; a carry into the exponent falls out of the add.
	function automatic logic [31:0] fp_pack(input logic sg, input logic [9:0] e,
			input logic [24:0] m);
		logic [32:0] pk;
		logic [31:0] r;
		pk = (({23'd0, e} - 33'd1) << 23) + {8'd0, m};
		if (pk >= {2'b00, 8'hff, 23'd0}) begin
			r = {sg, 8'hff, 23'd0};
		end else begin
			r = {sg, pk[30:0]};
		end
		return r;
	endfunction

	// fp32 addition, round to nearest even, subnormals kept.
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] r;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [8:0]  d;
		logic [26:0] mx;
		logic [26:0] my;
		logic [26:0] ms;
		logic        lost;
		logic [27:0] s;
		logic [4:0]  lz;
		logic        found;
		logic [9:0]  e;
		logic [9:0]  sh;
		logic [24:0] m;
		r = 32'd0;
		if (fp_is_nan(a)) begin
			r = a | QUIET_BIT;
		end else if (fp_is_nan(b)) begin
			r = b | QUIET_BIT;
		end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
			r = DEFAULT_NAN;
		end else if (fp_is_inf(a)) begin
			r = a;
		end else if (fp_is_inf(b)) begin
			r = b;
		end else begin
			if (a[30:0] >= b[30:0]) begin
				x = a;
				y = b;
			end else begin
				x = b;
				y = a;
			end
			ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
			ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
			mx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
			my = {(y[30:23] != 8'd0), y[22:0], 3'b000};
			d = {1'b0, ex} - {1'b0, ey};
			if (d > 9'd26) begin
				my = {26'd0, |my};
			end else begin
				ms = my >> d;
				lost = ((ms << d) != my);
				my = {ms[26:1], ms[0] | lost};
			end
			if (x[31] == y[31]) begin
				s = {1'b0, mx} + {1'b0, my};
			end else begin
				s = {1'b0, mx} - {1'b0, my};
			end
			if (s == 28'd0) begin
				r = {x[31] & y[31], 31'd0};
			end else begin
				e = {2'b00, ex};
				if (s[27]) begin
					s = {1'b0, s[27:2], s[1] | s[0]};
					e = e + 10'd1;
				end else begin
					lz = 5'd0;
					found = 1'b0;
					for (int i = 26; i >= 0; i--) begin
						if (!found) begin
							if (s[i]) begin
								found = 1'b1;
							end else begin
								lz = lz + 5'd1;
							end
						end
					end
					sh = ({5'd0, lz} < (e - 10'd1)) ? {5'd0, lz} : (e - 10'd1);
					s = s << sh;
					e = e - sh;
				end
				m = {1'b0, s[26:3]};
				if (s[2] && (s[1] || s[0] || m[0])) begin
					m = m + 25'd1;
				end
				r = fp_pack(x[31], e, m);
			end
		end
		return r;
	endfunction

	// a - b; a NaN in b comes back with its own sign.
	function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (!fp_is_nan(a) && fp_is_nan(b)) begin
			r = b | QUIET_BIT;
		end else begin
			r = fp_add(a, b ^ SIGN_BIT);
		end
		return r;
	endfunction

	// fp32 multiplication, round to nearest even, subnormals kept.
	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic        sg;
		logic [31:0] r;
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [47:0] p;
		logic [47:0] ps;
		logic        lost;
		logic [5:0]  lz;
		logic        found;
		logic [10:0] eo;
		logic [10:0] sh;
		logic [9:0]  e;
		logic [24:0] m;
		sg = a[31] ^ b[31];
		r = 32'd0;
		if (fp_is_nan(a)) begin
			r = a | QUIET_BIT;
		end else if (fp_is_nan(b)) begin
			r = b | QUIET_BIT;
		end else if ((fp_is_inf(a) && (b[30:0] == 31'd0)) ||
				(fp_is_inf(b) && (a[30:0] == 31'd0))) begin
			r = DEFAULT_NAN;
		end else if (fp_is_inf(a) || fp_is_inf(b)) begin
			r = {sg, 8'hff, 23'd0};
		end else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
			r = {sg, 31'd0};
		end else begin
			ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
			eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
			ma = {(a[30:23] != 8'd0), a[22:0]};
			mb = {(b[30:23] != 8'd0), b[22:0]};
			p = ma * mb;
			lz = 6'd0;
			found = 1'b0;
			for (int i = 47; i >= 0; i--) begin
				if (!found) begin
					if (p[i]) begin
						found = 1'b1;
					end else begin
						lz = lz + 6'd1;
					end
				end
			end
			p = p << lz;
			// Exponent carried with an offset of 191 so it stays positive.
			eo = {3'd0, ea} + {3'd0, eb} + 11'd65 - {5'd0, lz};
			if (eo < 11'd192) begin
				sh = 11'd192 - eo;
				if (sh > 11'd47) begin
					p = {47'd0, |p};
				end else begin
					ps = p >> sh;
					lost = ((ps << sh) != p);
					p = {ps[47:1], ps[0] | lost};
				end
				e = 10'd1;
			end else begin
				e = 10'(eo - 11'd191);
			end
			m = {1'b0, p[47:24]};
			if (p[23] && ((|p[22:0]) || m[0])) begin
				m = m + 25'd1;
			end
			r = fp_pack(sg, e, m);
		end
		return r;
	endfunction

	function automatic logic [31:0] fp_max_first(input logic [31:0] a, input logic [31:0] p);
		return fp_lt(a, p) ? p : a;
	endfunction

	// Exponent-halving square root estimate on the raw bit pattern.
	function automatic logic [31:0] fast_root(input logic [31:0] b);
		return {b[31], b[31:1]} + ROOT_BIAS;
	endfunction

endpackage

>>> rtl/bbsb_queue.sv
// Small first-in first-out queue of raw bit words.
// No dependencies; used between front and back and at the result side.
`timescale 1ns / 1ps

module bbsb_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic [CW-1:0]    count,
	output logic             is_empty,
	output logic             is_full
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data  = mem[rd_ptr_q];
	assign count    = count_q;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));

endmodule

>>> rtl/bbsb_front.sv
// Front part: takes points, applies the blend offset and keeps the running box.
// Depends on bbsb_pkg; hands finished boxes to the box queue.
`timescale 1ns / 1ps

module bbsb_front #(
	parameter int MQ_DEPTH = bbsb_pkg::MQ_DEPTH_DEF,
	localparam int CW = $clog2(MQ_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  bbsb_pkg::point_t point,
	input  logic [CW-1:0]    mq_count,
	output logic             mq_push,
	output bbsb_pkg::box_t   mq_box
);

	import bbsb_pkg::*;

	logic             v_s1;
	point_t           pnt_s1;
	logic [2:0][31:0] min_q;
	logic [2:0][31:0] max_q;
	logic             started_q;
	logic [2:0][31:0] pa;
	logic [2:0][31:0] pt;
	logic [2:0][31:0] off;
	logic [2:0][31:0] min_nx;
	logic [2:0][31:0] max_nx;
	logic [CW:0]      need;

	// Room for the box that the item now in stage one may still push.
	assign need = {1'b0, mq_count} + (CW + 1)'(v_s1 & pnt_s1.is_last);
	assign full = (need >= (CW + 1)'(MQ_DEPTH));

	assign pt  = {pnt_s1.point_z, pnt_s1.point_y, pnt_s1.point_x};
	assign off = {pnt_s1.offset_z, pnt_s1.offset_y, pnt_s1.offset_x};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pa[a] = pnt_s1.use_offset ? fp_add(pt[a], off[a]) : pt[a];
			if (!started_q) begin
				min_nx[a] = pa[a];
				max_nx[a] = pa[a];
			end else begin
				min_nx[a] = fp_lt(min_q[a], pa[a]) ? min_q[a] : pa[a];
				max_nx[a] = fp_lt(max_q[a], pa[a]) ? pa[a] : max_q[a];
			end
		end
	end

	assign mq_push   = v_s1 && pnt_s1.is_last;
	assign mq_box.lo = min_nx;
	assign mq_box.hi = max_nx;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			pnt_s1 <= point;
		end
		if (v_s1) begin
			min_q <= min_nx;
			max_q <= max_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			started_q <= 1'b0;
		end else begin
			v_s1 <= push && !full;
			if (v_s1) begin
				started_q <= !pnt_s1.is_last;
			end
		end
	end

endmodule

>>> rtl/bbsb_back.sv
// Back part: mirrors the box if asked, then center, half extents and radius.
// Depends on bbsb_pkg; reads the box queue and feeds the result queue.
`timescale 1ns / 1ps

module bbsb_back #(
	parameter int OQ_DEPTH = bbsb_pkg::OQ_DEPTH_DEF,
	localparam int CW = $clog2(OQ_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bbsb_pkg::mode_t   mode,
	input  logic              mq_empty,
	input  bbsb_pkg::box_t    mq_box,
	output logic              mq_pop,
	input  logic [CW-1:0]     oq_count,
	output logic              res_valid,
	output bbsb_pkg::result_t res
);

	import bbsb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	box_t             raw_s1;
	logic [2:0][31:0] lo_s2, hi_s2, lo_s3, hi_s3, lo_s4, hi_s4;
	logic [2:0][31:0] lo_s5, hi_s5, lo_s6, hi_s6;
	logic [2:0][31:0] d_s3, h_s4, c_s5, sq_s5, c_s6;
	logic [31:0]      t_s6, sz_s6;
	logic [2:0][31:0] ext;
	logic [2:0][31:0] lo_c, hi_c;
	logic [31:0]      m_all, m_xz, sum;
	int               pending;

	// Credit check: every box in flight has a reserved result slot.
	always_comb begin
		pending = int'(oq_count) + int'(v_s1) + int'(v_s2) + int'(v_s3) +
			int'(v_s4) + int'(v_s5) + int'(v_s6);
	end
	assign mq_pop = !mq_empty && (pending < OQ_DEPTH);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext[a] = fp_max_first(raw_s1.lo[a] & ~SIGN_BIT, raw_s1.hi[a]);
		end
		m_all = fp_max_first(ext[0], fp_max_first(ext[1], ext[2]));
		m_xz  = fp_max_first(ext[0], ext[2]);
		if (mode.cube) begin
			ext = {m_all, m_all, m_all};
		end else if (!mode.separate_xz) begin
			ext[0] = m_xz;
			ext[2] = m_xz;
		end
		for (int a = 0; a < 3; a++) begin
			hi_c[a] = mode.symmetric ? ext[a] : raw_s1.hi[a];
			lo_c[a] = mode.symmetric ? (ext[a] ^ SIGN_BIT) : raw_s1.lo[a];
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= mq_box;
		lo_s2  <= lo_c;
		hi_s2  <= hi_c;
		lo_s3  <= lo_s2;
		hi_s3  <= hi_s2;
		lo_s4  <= lo_s3;
		hi_s4  <= hi_s3;
		lo_s5  <= lo_s4;
		hi_s5  <= hi_s4;
		lo_s6  <= lo_s5;
		hi_s6  <= hi_s5;
		c_s6   <= c_s5;
		for (int a = 0; a < 3; a++) begin
			d_s3[a]  <= fp_sub(hi_s2[a], lo_s2[a]);
			h_s4[a]  <= fp_mul(d_s3[a], FP_HALF);
			c_s5[a]  <= fp_add(h_s4[a], lo_s4[a]);
			sq_s5[a] <= fp_mul(h_s4[a], h_s4[a]);
		end
		t_s6  <= fp_add(sq_s5[0], sq_s5[1]);
		sz_s6 <= sq_s5[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= mq_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign sum          = fp_add(t_s6, sz_s6);
	assign res_valid    = v_s6;
	assign res.min_x    = lo_s6[0];
	assign res.min_y    = lo_s6[1];
	assign res.min_z    = lo_s6[2];
	assign res.max_x    = hi_s6[0];
	assign res.max_y    = hi_s6[1];
	assign res.max_z    = hi_s6[2];
	assign res.center_x = c_s6[0];
	assign res.center_y = c_s6[1];
	assign res.center_z = c_s6[2];
	assign res.radius   = fast_root(sum);

endmodule

>>> rtl/bounding_box_and_sphere_builder.sv
// Top level of the bounding box and sphere builder: config registers and queues.
// Depends on bbsb_pkg, bbsb_queue, bbsb_front, bbsb_back and the assertion header.
//
//   channel   direction  handshake          payload
//   point     in         push / full        point_t   (one point per beat)
//   result    out        pop / empty        result_t  (one box per beat)
//   config    in         cfg_we             cfg_idx, cfg_data
//
// Points are accepted one per cycle, back to back, while full stays low. The
// front adds the offset and updates the running box in the cycle after a
// point is taken; the point marked last lands its box in the box queue then.
// The back is a six-stage pipeline (capture, mirror, subtract, halve, center
// and squares, two adds and root) and takes a new box every cycle while a
// result slot is free. The block stalls input only when the box queue fills,
// which happens only when results are popped more slowly than boxes arrive.
// Reset clears the queues, the run state and the mode registers; no clearing
// pass is needed.
`timescale 1ns / 1ps
`include "bounding_box_and_sphere_builder_assert.svh"

module bounding_box_and_sphere_builder #(
	parameter int MQ_DEPTH = bbsb_pkg::MQ_DEPTH_DEF,
	parameter int OQ_DEPTH = bbsb_pkg::OQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bbsb_pkg::point_t  point,
	output logic              empty,
	input  logic              pop,
	output bbsb_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [0:0]        cfg_data
);

	import bbsb_pkg::*;

	localparam int MCW = $clog2(MQ_DEPTH + 1);
	localparam int OCW = $clog2(OQ_DEPTH + 1);

	mode_t          mode_q;
	logic           mq_push, mq_pop, mq_empty, mq_full;
	logic [MCW-1:0] mq_count;
	box_t           mq_wbox, mq_rbox;
	logic           oq_push, oq_pop, oq_empty, oq_full;
	logic [OCW-1:0] oq_count;
	result_t        oq_wres, oq_rres;

	// Mode registers; writes are only expected while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_SYMMETRIC:   mode_q.symmetric   <= cfg_data[0];
				REG_CUBE:        mode_q.cube        <= cfg_data[0];
				REG_SEPARATE_XZ: mode_q.separate_xz <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bbsb_front #(.MQ_DEPTH(MQ_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.point    (point),
		.mq_count (mq_count),
		.mq_push  (mq_push),
		.mq_box   (mq_wbox)
	);

	bbsb_queue #(.WIDTH($bits(box_t)), .DEPTH(MQ_DEPTH)) u_box_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mq_push),
		.wr_data  (mq_wbox),
		.rd_en    (mq_pop),
		.rd_data  (mq_rbox),
		.count    (mq_count),
		.is_empty (mq_empty),
		.is_full  (mq_full)
	);

	bbsb_back #(.OQ_DEPTH(OQ_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.mq_empty  (mq_empty),
		.mq_box    (mq_rbox),
		.mq_pop    (mq_pop),
		.oq_count  (oq_count),
		.res_valid (oq_push),
		.res       (oq_wres)
	);

	// Result queue: its head is the oldest result waiting to be popped.
	assign oq_pop = pop && !oq_empty;

	bbsb_queue #(.WIDTH($bits(result_t)), .DEPTH(OQ_DEPTH)) u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (oq_push),
		.wr_data  (oq_wres),
		.rd_en    (oq_pop),
		.rd_data  (oq_rres),
		.count    (oq_count),
		.is_empty (oq_empty),
		.is_full  (oq_full)
	);

	assign empty  = oq_empty;
	assign result = oq_rres;

	// The front reserves box queue room before it takes a point.
	`BBSB_ASSERT_IMPLIES(a_box_queue_room, mq_push, !mq_full || mq_pop, "box queue overflow")
	// The back only issues when a result slot is reserved.
	`BBSB_ASSERT_IMPLIES(a_result_queue_room, oq_push, !oq_full, "result queue overflow")
	// A pop with no concurrent push frees exactly one result slot.
	`BBSB_ASSERT_NEXT(a_pop_drains, oq_pop && !oq_push, (oq_count + OCW'(1)) == $past(oq_count), "result count did not drop after a pop")

endmodule

>>> sim/box_checker.sv
// Scoreboard for the bounding box and sphere builder: watches the point, result and
// configuration channels, predicts every box in its own fp32 arithmetic and compares.
// Depends on bbsb_pkg for the payload types, register indexes and fp32 constants.
`timescale 1ns / 1ps

module box_checker
	import bbsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  point_t      point,
	input  logic        pop,
	input  logic        empty,
	input  result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [0:0]  cfg_data,
	output int          failures,
	output int          pending,
	output int          points_seen,
	output int          boxes_seen
);

	logic [31:0] box_lo [3];
	logic [31:0] box_hi [3];
	logic        run_open;
	logic        sym_mode;
	logic        cube_on;
	logic        keep_xz;
	result_t     expected_boxes [$];
	int          fail_count;
	int          point_count;
	int          box_count;
	int          pending_count;

	assign failures    = fail_count;
	assign pending     = pending_count;
	assign points_seen = point_count;
	assign boxes_seen  = box_count;

	function automatic logic is_nan(input logic [31:0] a);
		return (&a[30:23]) && (|a[22:0]);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (&a[30:23]) && !(|a[22:0]);
	endfunction

	// Maps a non-NaN pattern onto an unsigned key that sorts like the float.
	function automatic logic [31:0] order_key(input logic [31:0] a);
		return a[31] ? ~a : (a | SIGN_BIT);
	endfunction

	function automatic logic less_than(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return 1'b0;
		return order_key(a) < order_key(b);
	endfunction

	function automatic logic [31:0] larger(input logic [31:0] a, input logic [31:0] p);
		return less_than(a, p) ? p : a;
	endfunction

	function automatic logic [31:0] smaller(input logic [31:0] a, input logic [31:0] p);
		return less_than(a, p) ? a : p;
	endfunction

	// Round to nearest even and pack; a clear leading bit means a subnormal.
	function automatic logic [31:0] round_pack(input logic sg, input int e,
			input logic [23:0] m, input logic g, input logic st);
		logic [24:0] mm;
		int          ee;
		mm = {1'b0, m};
		ee = e;
		if (g && (st || m[0]))
			mm = mm + 25'd1;
		if (mm[24]) begin
			mm = mm >> 1;
			ee = ee + 1;
		end
		if (ee >= 255)
			return {sg, 8'hff, 23'd0};
		if (!mm[23])
			return {sg, 8'd0, mm[22:0]};
		return {sg, ee[7:0], mm[22:0]};
	endfunction

	function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] big;
		logic [31:0] sml;
		logic [27:0] mb;
		logic [27:0] ms;
		logic [27:0] sum;
		logic        sticky;
		int          eb;
		int          es;
		int          d;
		int          e;
		if (is_nan(a))
			return a | QUIET_BIT;
		if (is_nan(b))
			return b | QUIET_BIT;
		if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
			return DEFAULT_NAN;
		if (is_inf(a))
			return a;
		if (is_inf(b))
			return b;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
		es = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
		mb = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b000};
		ms = {1'b0, sml[30:23] != 8'd0, sml[22:0], 3'b000};
		d = eb - es;
		if (d > 27) begin
			ms = {27'd0, |ms};
		end else begin
			sticky = |(ms & ((28'd1 << d) - 28'd1));
			ms = (ms >> d) | {27'd0, sticky};
		end
		sum = (big[31] == sml[31]) ? mb + ms : mb - ms;
		if (sum == 28'd0)
			return {big[31] & sml[31], 31'd0};
		e = eb;
		if (sum[27]) begin
			sum = (sum >> 1) | {27'd0, sum[0]};
			e = e + 1;
		end else begin
			while (!sum[26] && e > 1) begin
				sum = sum << 1;
				e = e - 1;
			end
		end
		return round_pack(big[31], e, sum[26:3], sum[2], |sum[1:0]);
	endfunction

	// hi - lo; a NaN on the right keeps its own sign.
	function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b);
		if (!is_nan(a) && is_nan(b))
			return b | QUIET_BIT;
		return f32_add(a, b ^ SIGN_BIT);
	endfunction

	function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
		logic        sg;
		logic [47:0] p;
		logic        sticky;
		int          ea;
		int          eb;
		int          lz;
		int          e;
		int          sh;
		sg = a[31] ^ b[31];
		if (is_nan(a))
			return a | QUIET_BIT;
		if (is_nan(b))
			return b | QUIET_BIT;
		if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
			return DEFAULT_NAN;
		if (is_inf(a) || is_inf(b))
			return {sg, 8'hff, 23'd0};
		if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
			return {sg, 31'd0};
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		p = {24'd0, a[30:23] != 8'd0, a[22:0]} * {24'd0, b[30:23] != 8'd0, b[22:0]};
		lz = 0;
		while (!p[47]) begin
			p = p << 1;
			lz = lz + 1;
		end
		e = ea + eb - 126 - lz;
		if (e < 1) begin
			sh = 1 - e;
			if (sh > 47) begin
				p = {47'd0, |p};
			end else begin
				sticky = |(p & ((48'd1 << sh) - 48'd1));
				p = (p >> sh) | {47'd0, sticky};
			end
			e = 1;
		end
		return round_pack(sg, e, p[47:24], p[23], |p[22:0]);
	endfunction

	// Square root estimate: arithmetic halving of the pattern, then the bias.
	function automatic logic [31:0] root_estimate(input logic [31:0] v);
		return 32'($signed(v) >>> 1) + ROOT_BIAS;
	endfunction

	task automatic take_point(input point_t pt);
		logic [31:0] pv [3];
		logic [31:0] ov [3];
		logic [31:0] lo [3];
		logic [31:0] hi [3];
		logic [31:0] ext [3];
		logic [31:0] half [3];
		logic [31:0] ctr [3];
		logic [31:0] widest;
		logic [31:0] sq_sum;
		result_t     r;
		pv = '{pt.point_x, pt.point_y, pt.point_z};
		ov = '{pt.offset_x, pt.offset_y, pt.offset_z};
		for (int a = 0; a < 3; a++) begin
			if (pt.use_offset)
				pv[a] = f32_add(pv[a], ov[a]);
			box_lo[a] = run_open ? smaller(box_lo[a], pv[a]) : pv[a];
			box_hi[a] = run_open ? larger(box_hi[a], pv[a]) : pv[a];
		end
		run_open = 1'b1;
		point_count++;
		if (!pt.is_last)
			return;
		run_open = 1'b0;
		if (sym_mode) begin
			for (int a = 0; a < 3; a++)
				ext[a] = larger(box_lo[a] & ~SIGN_BIT, box_hi[a]);
			if (cube_on) begin
				widest = larger(ext[0], larger(ext[1], ext[2]));
				ext = '{widest, widest, widest};
			end else if (!keep_xz) begin
				widest = larger(ext[0], ext[2]);
				ext[0] = widest;
				ext[2] = widest;
			end
			for (int a = 0; a < 3; a++) begin
				hi[a] = ext[a];
				lo[a] = ext[a] ^ SIGN_BIT;
			end
		end else begin
			lo = box_lo;
			hi = box_hi;
		end
		for (int a = 0; a < 3; a++) begin
			half[a] = f32_mul(f32_sub(hi[a], lo[a]), FP_HALF);
			ctr[a] = f32_add(half[a], lo[a]);
		end
		sq_sum = f32_add(f32_add(f32_mul(half[0], half[0]), f32_mul(half[1], half[1])),
			f32_mul(half[2], half[2]));
		r.min_x = lo[0];
		r.min_y = lo[1];
		r.min_z = lo[2];
		r.max_x = hi[0];
		r.max_y = hi[1];
		r.max_z = hi[2];
		r.center_x = ctr[0];
		r.center_y = ctr[1];
		r.center_z = ctr[2];
		r.radius = root_estimate(sq_sum);
		expected_boxes.push_back(r);
	endtask

	task automatic check_word(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			box_lo = '{32'd0, 32'd0, 32'd0};
			box_hi = '{32'd0, 32'd0, 32'd0};
			run_open = 1'b0;
			sym_mode = 1'b0;
			cube_on = 1'b0;
			keep_xz = 1'b0;
			expected_boxes.delete();
			fail_count = 0;
			point_count = 0;
			box_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_SYMMETRIC: sym_mode = cfg_data[0];
					REG_CUBE: cube_on = cfg_data[0];
					REG_SEPARATE_XZ: keep_xz = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full)
				take_point(point);
			if (pop && !empty) begin
				if (expected_boxes.size() == 0) begin
					$error("result beat with no box expected");
					fail_count++;
				end else begin
					want = expected_boxes.pop_front();
					check_word("min_x", want.min_x, result.min_x);
					check_word("min_y", want.min_y, result.min_y);
					check_word("min_z", want.min_z, result.min_z);
					check_word("max_x", want.max_x, result.max_x);
					check_word("max_y", want.max_y, result.max_y);
					check_word("max_z", want.max_z, result.max_z);
					check_word("center_x", want.center_x, result.center_x);
					check_word("center_y", want.center_y, result.center_y);
					check_word("center_z", want.center_z, result.center_z);
					check_word("radius", want.radius, result.radius);
				end
				box_count++;
			end
			pending_count = expected_boxes.size();
		end
	end

endmodule

>>> sim/testbench.sv
// Top of the bounding box and sphere builder testbench: clock, reset, point and
// configuration stimulus, result-side back-pressure and the final verdict.
// Depends on bbsb_pkg, the block itself and the box_checker scoreboard.
`timescale 1ns / 1ps

module testbench;
	import bbsb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_POINTS = 110;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	point_t      point = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = 2'd0;
	logic [0:0]  cfg_data = 1'b0;

	int          failures;
	int          pending;
	int          points_seen;
	int          boxes_seen;
	int          cycles = 0;
	bit          hold_results = 1'b0;

	bounding_box_and_sphere_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.point(point),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	box_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.point(point),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending),
		.points_seen(points_seen),
		.boxes_seen(boxes_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// A hung handshake would otherwise run forever, so the cycle count caps the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Gap lengths: mostly none, some short, and now and then a long one.
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Coordinates mix ordinary magnitudes with the awkward corners of fp32:
	// zeros of both signs, infinities, NaNs, subnormals and values whose squares
	// overflow, plus fully random patterns so every bit toggles.
	function automatic logic [31:0] rand_coord();
		logic [31:0] corner [9];
		corner = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
			32'hffc00001, 32'h7f800001, 32'h00000001, 32'h7f7fffff};
		case ($urandom_range(0, 9))
			5: return $urandom;
			6: return corner[$urandom_range(0, 8)];
			7: return {1'($urandom), 8'd0, 23'($urandom)};
			8: return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
			9: return {1'($urandom), 8'($urandom_range(127, 131)), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
		endcase
	endfunction

	function automatic point_t make_point(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] oz, input logic with_offset, input logic last);
		point_t p;
		p.point_x = px;
		p.point_y = py;
		p.point_z = pz;
		p.offset_x = ox;
		p.offset_y = oy;
		p.offset_z = oz;
		p.use_offset = with_offset;
		p.is_last = last;
		return p;
	endfunction

	// Offers one point and holds it until the block takes the beat. Push is not
	// lowered here, so back-to-back points keep it high without a glitch.
	task automatic send_point(input point_t p);
		push <= 1'b1;
		point <= p;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic sender_gap(input int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Lets the block drain completely, until every predicted box has been popped.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Writes all three mode registers, one per cycle, while the block is idle.
	task automatic write_modes(input logic sym, input logic cube, input logic sep);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SYMMETRIC;
		cfg_data <= sym;
		@(posedge clk);
		cfg_idx <= REG_CUBE;
		cfg_data <= cube;
		@(posedge clk);
		cfg_idx <= REG_SEPARATE_XZ;
		cfg_data <= sep;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Hand-picked runs: single-point runs, signed zeros, NaN first and later in
	// a run, infinities, offsets that produce NaN, overflow and subnormals, and
	// all-negative boxes whose mirrored extent comes from the minimum.
	task automatic directed_runs();
		send_point(make_point(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		send_point(make_point(32'h00000000, 32'h80000000, 0, 0, 0, 0, 1'b0, 1'b0));
		send_point(make_point(32'h80000000, 32'h00000000, 32'h80000000, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'h7fc00000, 32'h3f800000, 32'hff800001, 0, 0, 0,
			1'b0, 1'b0));
		send_point(make_point(32'h3f800000, 32'hc0000000, 32'h40a00000, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'h3f800000, 32'h40000000, 32'h40400000, 0, 0, 0,
			1'b0, 1'b0));
		send_point(make_point(32'h7fc00000, 32'hff800001, 32'h7f800001, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'h7f800000, 32'hff800000, 0, 0, 0, 0, 1'b0, 1'b0));
		send_point(make_point(32'hff800000, 32'h7f800000, 32'h3f800000, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'h7f800000, 32'h3f800000, 32'h00000001,
			32'hff800000, 32'h40000000, 32'h00000001, 1'b1, 1'b0));
		send_point(make_point(32'h7f7fffff, 32'hff7fffff, 32'h80000001,
			32'h7f7fffff, 32'hff7fffff, 32'h00000001, 1'b1, 1'b1));
		send_point(make_point(32'h7f7fffff, 32'hff7fffff, 32'h7f7fffff, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'h00000001, 32'h80000001, 32'h007fffff, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'hc0400000, 32'hbf800000, 32'hc0e00000, 0, 0, 0,
			1'b0, 1'b0));
		send_point(make_point(32'hc0000000, 32'hc0a00000, 32'hc1100000, 0, 0, 0,
			1'b0, 1'b1));
		send_point(make_point(32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1));
	endtask

	// One run of random length; a few points are pure noise patterns.
	task automatic random_run(output int sent, input bit no_gaps);
		int len;
		point_t p;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom)};
				p.is_last = (i == len - 1);
			end else begin
				p = make_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), 1'($urandom), i == len - 1);
			end
			send_point(p);
			if (!no_gaps)
				sender_gap(rand_gap());
		end
		sent = len;
	endtask

	// Result side: pops in bursts and stalls of random length, and honors a
	// request for one long hold-off so the box queue fills and input backs up.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_results = 1'b0;
			end else if ($urandom_range(0, 1) == 0) begin
				pop <= 1'b1;
				repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 60)
					: $urandom_range(1, 8)) @(posedge clk);
			end else begin
				pop <= 1'b0;
				repeat (rand_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		int sent;
		int total;
		logic [2:0] mode;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed runs first with the reset modes, then mirrored with x and z merged.
		directed_runs();
		drain();
		write_modes(1'b1, 1'b0, 1'b0);
		directed_runs();
		drain();

		// Every mode setting in turn, then one random setting; each phase starts idle.
		for (int ph = 0; ph < 9; ph++) begin
			mode = (ph < 8) ? 3'(ph) : 3'($urandom);
			write_modes(mode[0], mode[1], mode[2]);
			if (ph == 3) begin
				// Back-pressure: results are held off while single-point runs stream in.
				hold_results = 1'b1;
				for (int i = 0; i < 40; i++)
					send_point(make_point(rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), rand_coord(), rand_coord(), 1'($urandom), 1'b1));
			end
			total = 0;
			while (total < PHASE_POINTS) begin
				random_run(sent, ph == 5);
				total += sent;
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d points and %0d boxes over all eight mode settings,",
			points_seen, boxes_seen);
		$display("with directed fp32 corners, random runs and a full-queue stall.");
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/bbsb_pkg.sv
rtl/bbsb_queue.sv
rtl/bbsb_front.sv
rtl/bbsb_back.sv
rtl/bounding_box_and_sphere_builder.sv
sim/box_checker.sv
sim/testbench.sv
